// ===== hdl/ffira_pkg.sv =====
package ffira_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int ADDR_W       = 48;
    localparam int END_W        = 49;
    localparam int ROW_W        = 4;
    localparam int COUNT_W      = 5;

    typedef struct packed {
        logic [ADDR_W-1:0] start_address;
        logic [ADDR_W-1:0] size_bytes;
        logic              is_heap;
        logic              last_in_allocation;
    } ffira_in_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic               skipped;
        logic               overflow;
        logic [COUNT_W-1:0] rows_used;
        logic               aliased;
        logic               last;
    } ffira_out_t;

endpackage

// ===== hdl/ffira_ram.sv =====
module ffira_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/first_fit_interval_row_assigner.sv =====
// channel | signals                        | word
// --------+--------------------------------+-------------------------------
// input   | in_valid, in_ready, in_data    | ffira_in_t: one resource range
// output  | out_valid, out_ready, out_data | ffira_out_t: row result
//
// An item first fitting at row k scans rows 0 to k; one that opens a new row
// or overflows scans all rows_open rows; a heap item skips the scan. The scan
// reads row ends in turn through the single read port of the row-end RAM.
// Reset clears the row count and the handshake state; row-end RAM is not reset.
// A new word is taken while the last result still waits in the output register;
// a finished result waits in its own register until the output one is free.
module first_fit_interval_row_assigner #(
    parameter int MAX_ROWS = ffira_pkg::MAX_ROWS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ffira_pkg::ffira_in_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ffira_pkg::ffira_out_t  out_data
);

    import ffira_pkg::*;

    localparam int IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int ROWX_W = (IDX_W > ROW_W) ? IDX_W : ROW_W;
    localparam int CNTX_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg,     state_next;
    logic [CNT_W-1:0]  rows_open_reg, rows_open_next;
    logic [CNT_W-1:0]  rd_idx_reg,    rd_idx_next;
    logic [IDX_W-1:0]  cmp_idx_reg,   cmp_idx_next;
    logic              cmp_vld_reg,   cmp_vld_next;
    logic [ADDR_W-1:0] start_reg;
    logic [END_W-1:0]  end_reg;
    logic              last_reg;
    ffira_out_t        res_reg,       res_next;
    ffira_out_t        out_reg,       out_next;
    logic              out_valid_reg, out_valid_next;

    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic              ram_rd_en;
    logic [END_W-1:0]  ram_rd_data;

    logic              accept;
    logic              fit;
    logic              rd_done;
    logic              finish;
    logic              res_skip;
    logic              res_ovf;
    logic [IDX_W-1:0]  res_idx;
    logic [CNT_W-1:0]  res_count;
    logic [ROWX_W-1:0] row_x;
    logic [CNTX_W-1:0] count_x;
    logic              res_last;

    ffira_ram #(
        .WIDTH (END_W),
        .DEPTH (MAX_ROWS),
        .AW    (IDX_W)
    ) u_row_end (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (end_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign fit     = cmp_vld_reg && ({1'b0, start_reg} >= ram_rd_data);
    assign rd_done = (rd_idx_reg == rows_open_reg);

    always_comb
    begin
        state_next     = state_reg;
        rows_open_next = rows_open_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = 1'b0;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = cmp_idx_reg;
        ram_rd_en      = 1'b0;
        finish         = 1'b0;
        res_skip       = 1'b0;
        res_ovf        = 1'b0;
        res_idx        = '0;
        res_count      = rows_open_reg;
        res_last       = last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_idx_next = '0;
                    if (in_data.is_heap)
                    begin
                        finish     = 1'b1;
                        res_skip   = 1'b1;
                        res_last   = in_data.last_in_allocation;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (fit)
                begin
                    finish      = 1'b1;
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = cmp_idx_reg;
                    res_idx     = cmp_idx_reg;
                    state_next  = S_DONE;
                end
                else if (rd_done)
                begin
                    finish     = 1'b1;
                    state_next = S_DONE;
                    if (rows_open_reg < CNT_W'(MAX_ROWS))
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = rows_open_reg[IDX_W-1:0];
                        res_idx     = rows_open_reg[IDX_W-1:0];
                        res_count   = rows_open_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res_ovf = 1'b1;
                    end
                end
                else
                begin
                    ram_rd_en    = 1'b1;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    cmp_vld_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        row_x   = ROWX_W'(res_idx);
        count_x = CNTX_W'(res_count);

        if (finish)
        begin
            res_next.row       = row_x[ROW_W-1:0];
            res_next.skipped   = res_skip;
            res_next.overflow  = res_ovf;
            res_next.rows_used = count_x[COUNT_W-1:0];
            res_next.aliased   = (res_count > CNT_W'(1));
            res_next.last      = res_last;
            rows_open_next     = res_last ? '0 : res_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_open_reg <= '0;
            rd_idx_reg    <= '0;
            cmp_idx_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_open_reg <= rows_open_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg <= in_data.start_address;
            end_reg   <= {1'b0, in_data.start_address} + {1'b0, in_data.size_bytes};
            last_reg  <= in_data.last_in_allocation;
        end
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule
